// ===== sv/mpaq_pkg.sv =====
// mpaq_pkg: types and constants for the mouse packet assembler queue
// no dependencies; imported by the core and the testbench
package mpaq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    localparam int DATA_W      = 8;
    localparam int BTN_W       = 3;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    localparam logic [DATA_W-1:0] SYNC_BIT    = 8'h08;
    localparam logic [DATA_W-1:0] BUTTON_MASK = 8'h07;

    // item kind carried on s_axis_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [BTN_W-1:0]        buttons;
        logic signed [DATA_W-1:0] dy;
        logic signed [DATA_W-1:0] dx;
    } event_t;

    // packed so that the last field lands in the lowest bit
    typedef struct packed {
        logic                     pad;
        logic [BTN_W-1:0]         button_bits;
        logic signed [DATA_W-1:0] delta_y;
        logic signed [DATA_W-1:0] delta_x;
        logic                     pop_valid;
        logic                     packet_dropped;
        logic                     packet_complete;
        logic                     resync_discard;
    } result_t;

    function automatic ptr_t next_slot(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

endpackage

// ===== sv/mouse_packet_assembler_queue_core.sv =====
// Mouse packet framer with a ring queue of decoded events.
// Usage:
//   s_axis: one item per handshake. tuser = operation (0 = mouse byte,
//   1 = pop oldest event), tdata = data_byte (ignored on pops).
//   m_axis: exactly one result item per input item, in order. tdata packs
//   resync_discard, packet_complete, packet_dropped, pop_valid, delta_x,
//   delta_y, button_bits from the lowest bit up, one zero pad bit on top.
// Timing:
//   an accepted item sits in the input register, is decoded by a single
//   level of framing/queue logic and lands in the result register, from
//   which it is offered on m_axis. Throughput is one item per cycle while
//   m_axis_tready stays high; phase and queue pointers update per item.
// Reset (aresetn low, synchronous): phase, packet bytes and both pointers go
//   to zero, the queue is empty and both registers are empty. Event slots are
//   not cleared; only written slots are ever popped.
// Stall: while m_axis_tready is low the result holds, the input register
//   keeps one more item, and s_axis_tready drops once that register is full.
//   The queue holds QUEUE_DEPTH-1 events; a packet that finds it full is
//   reported with packet_dropped and discarded.
module mouse_packet_assembler_queue_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mpaq_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic                            s_axis_tuser,  // [0] operation
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] resync_discard, [1] packet_complete, [2] packet_dropped,
    // [3] pop_valid, [11:4] delta_x, [19:12] delta_y, [22:20] button_bits,
    // [23] zero
    output logic [mpaq_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import mpaq_pkg::*;

    // input register
    logic              in_valid_reg;
    logic              in_op_reg;
    logic [DATA_W-1:0] in_byte_reg;

    // result register
    logic    out_valid_reg;
    result_t out_reg;

    // framer and queue state
    phase_t            phase_reg, phase_next;
    logic [BTN_W-1:0]  first_btn_reg;
    logic [DATA_W-1:0] second_byte_reg;
    ptr_t              wr_ptr_reg, wr_ptr_next;
    ptr_t              rd_ptr_reg, rd_ptr_next;
    event_t            event_mem [QUEUE_DEPTH];
    event_t            head_event_reg;

    logic    advance;
    logic    is_byte;
    logic    queue_empty;
    logic    queue_full;
    logic    push;
    event_t  new_event;
    result_t res_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign is_byte     = (in_op_reg == OP_BYTE);
    assign queue_empty = (rd_ptr_reg == wr_ptr_reg);
    assign queue_full  = (next_slot(wr_ptr_reg) == rd_ptr_reg);

    assign new_event.buttons = first_btn_reg;
    assign new_event.dx      = second_byte_reg;
    assign new_event.dy      = in_byte_reg;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (is_byte) begin
            case (phase_reg)
                PH_FIRST: begin
                    if ((in_byte_reg & SYNC_BIT) != '0) begin
                        phase_next = PH_SECOND;
                    end
                end
                PH_SECOND: begin
                    phase_next = PH_THIRD;
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    // result fields and queue updates
    always_comb begin
        res_next    = '0;
        push        = 1'b0;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (!is_byte) begin
            if (!queue_empty) begin
                res_next.pop_valid   = 1'b1;
                res_next.delta_x     = head_event_reg.dx;
                res_next.delta_y     = head_event_reg.dy;
                res_next.button_bits = head_event_reg.buttons;
                rd_ptr_next          = next_slot(rd_ptr_reg);
            end
        end else begin
            case (phase_reg)
                PH_FIRST: begin
                    res_next.resync_discard = ((in_byte_reg & SYNC_BIT) == '0);
                end
                PH_SECOND: begin
                    res_next = '0;
                end
                default: begin
                    // third byte, or an out-of-range phase
                    res_next.packet_complete = 1'b1;
                    if (queue_full) begin
                        res_next.packet_dropped = 1'b1;
                    end else begin
                        push        = 1'b1;
                        wr_ptr_next = next_slot(wr_ptr_reg);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= PH_FIRST;
            first_btn_reg   <= '0;
            second_byte_reg <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (advance) begin
                phase_reg  <= phase_next;
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
                if (is_byte && phase_reg == PH_FIRST) begin
                    first_btn_reg <= BTN_W'(in_byte_reg & BUTTON_MASK);
                end
                if (is_byte && phase_reg == PH_SECOND) begin
                    second_byte_reg <= in_byte_reg;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata[DATA_W-1:0];
        end
        if (advance) begin
            out_reg <= res_next;
            // head of queue for the next pop, forwarded when pushed into an empty queue
            if (push && wr_ptr_reg == rd_ptr_next) begin
                head_event_reg <= new_event;
            end else begin
                head_event_reg <= event_mem[rd_ptr_next];
            end
        end
        if (advance && push) begin
            event_mem[wr_ptr_reg] <= new_event;
        end
    end

endmodule

// ===== sv/mpaq_checker.sv =====
// mpaq_checker: port-level checks on the mouse packet assembler queue core
// depends on nothing but the core's ports; bound to the core below
module mpaq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an item is at most one of a discard, a completed packet or a pop, never two
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> $onehot0({m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[3]}))
        else $error("more than one result kind");

    // only a completed packet can be dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1])
        else $error("drop without complete packet");

    // event fields are zero unless a pop returned an event
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[3] |-> m_axis_tdata[23:4] == 20'd0)
        else $error("event fields set without pop");

    // both registers are empty right after reset
    assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready && !m_axis_tvalid)
        else $error("not empty after reset");

endmodule

bind mouse_packet_assembler_queue_core mpaq_checker u_mpaq_checker (.*);

// ===== test/mouse_packet_assembler_queue_core_tb.sv =====
`timescale 1ns / 100ps
// testbench for mouse_packet_assembler_queue_core: framing, resync, event queue and pops
// depends on mpaq_pkg and the core; a scoreboard class predicts one result per input item

module mouse_packet_assembler_queue_core_tb;
    import mpaq_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_LIMIT   = 400;
    localparam int DRAIN_CYCLES = 8;

    // predicts the result of each accepted item and checks results in order
    class mouse_event_scoreboard;
        phase_t           phase;
        logic [7:0]       first_held;
        logic [7:0]       second_held;
        event_t           slots [QUEUE_DEPTH];
        int unsigned      wr_idx;
        int unsigned      rd_idx;
        result_t          expected_results [$];
        int               errors;
        int               checked;
        int               completed;
        int               dropped;
        int               resyncs;
        int               pops_hit;
        int               pops_empty;

        function new();
            phase       = PH_FIRST;
            first_held  = '0;
            second_held = '0;
            wr_idx      = 0;
            rd_idx      = 0;
            errors      = 0;
            checked     = 0;
            completed   = 0;
            dropped     = 0;
            resyncs     = 0;
            pops_hit    = 0;
            pops_empty  = 0;
        endfunction

        function void note_item(logic op, logic [7:0] b);
            result_t r;
            event_t  ev;
            r = '0;
            if (op == OP_POP) begin
                if (rd_idx != wr_idx) begin
                    ev            = slots[rd_idx];
                    r.pop_valid   = 1'b1;
                    r.delta_x     = ev.dx;
                    r.delta_y     = ev.dy;
                    r.button_bits = ev.buttons;
                    rd_idx        = (rd_idx + 1) % QUEUE_DEPTH;
                    pops_hit++;
                end else begin
                    pops_empty++;
                end
            end else begin
                case (phase)
                    PH_FIRST: begin
                        if ((b & SYNC_BIT) == '0) begin
                            r.resync_discard = 1'b1;
                            resyncs++;
                        end else begin
                            first_held = b;
                            phase      = PH_SECOND;
                        end
                    end
                    PH_SECOND: begin
                        second_held = b;
                        phase       = PH_THIRD;
                    end
                    default: begin
                        phase             = PH_FIRST;
                        r.packet_complete = 1'b1;
                        completed++;
                        ev.dx      = second_held;
                        ev.dy      = b;
                        ev.buttons = first_held[BTN_W-1:0];
                        // one slot always stays empty
                        if ((wr_idx + 1) % QUEUE_DEPTH == rd_idx) begin
                            r.packet_dropped = 1'b1;
                            dropped++;
                        end else begin
                            slots[wr_idx] = ev;
                            wr_idx        = (wr_idx + 1) % QUEUE_DEPTH;
                        end
                    end
                endcase
            end
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            result_t act;
            result_t want;
            act = result_t'(tdata);
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with no item pending, expected none, actual %h",
                         $time, tdata);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            compare_field("resync_discard", want.resync_discard, act.resync_discard);
            compare_field("packet_complete", want.packet_complete, act.packet_complete);
            compare_field("packet_dropped", want.packet_dropped, act.packet_dropped);
            compare_field("pop_valid", want.pop_valid, act.pop_valid);
            compare_field("delta_x", want.delta_x, act.delta_x);
            compare_field("delta_y", want.delta_y, act.delta_y);
            compare_field("button_bits", want.button_bits, act.button_bits);
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = OP_BYTE;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    mouse_event_scoreboard sb = new();
    bit                    tx_steady = 1'b0;
    int                    items_sent = 0;
    int                    idle_cycles = 0;

    mouse_packet_assembler_queue_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic int draw_wait(bit steady);
        return steady ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic logic [7:0] pick_delta();
        case ($urandom_range(0, 7))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            3: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = draw_wait(tx_steady);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_item(op, b);
        items_sent++;
    endtask

    task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
                               input logic [7:0] dy, input bit pop_inside);
        send_item(OP_BYTE, head);
        // a pop between packet bytes must not disturb framing
        if (pop_inside) send_item(OP_POP, 8'($urandom_range(0, 255)));
        send_item(OP_BYTE, dx);
        send_item(OP_BYTE, dy);
    endtask

    // result side: random stalls with occasional stretches of steady acceptance
    initial begin
        int  stall;
        int  run_left;
        bit  rx_steady;
        run_left  = 0;
        rx_steady = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (run_left == 0) begin
                rx_steady = ($urandom_range(0, 3) == 0);
                run_left  = $urandom_range(10, 40);
            end
            run_left--;
            stall = draw_wait(rx_steady);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("mouse_packet_assembler_queue_core test failed");
                $finish;
            end
        end
    end

    initial begin
        int  mode;
        int  span;
        int  roll;
        int  pkt_pct;
        int  pop_pct;
        int  random_start;
        bit  first_episode;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty pops, resync bytes, packets with extreme deltas and buttons
        send_item(OP_POP, 8'hFF);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hF7);
        send_packet(8'h0F, 8'h80, 8'h7F, 1'b0);
        send_packet(8'h08, 8'h7F, 8'h80, 1'b0);
        send_packet(8'hFF, 8'hFF, 8'h00, 1'b1);
        send_item(OP_POP, 8'h00);
        send_item(OP_POP, 8'hAA);
        send_item(OP_POP, 8'h55);
        send_item(OP_POP, 8'h00);
        send_packet(8'hF8, 8'h00, 8'hFF, 1'b0);
        send_item(OP_POP, 8'hFF);

        // random episodes; the first one fills the queue past full
        random_start  = items_sent;
        first_episode = 1'b1;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            mode          = first_episode ? 0 : $urandom_range(0, 3);
            span          = first_episode ? 20 : $urandom_range(8, 30);
            first_episode = 1'b0;
            tx_steady     = ($urandom_range(0, 3) == 0);
            case (mode)
                0: begin pkt_pct = 90; pop_pct = 3;  end // fill
                1: begin pkt_pct = 20; pop_pct = 75; end // drain
                2: begin pkt_pct = 45; pop_pct = 45; end
                default: begin pkt_pct = 30; pop_pct = 20; end // mostly noise
            endcase
            repeat (span) begin
                roll = $urandom_range(0, 99);
                if (roll < pkt_pct) begin
                    send_packet(8'($urandom_range(0, 255)) | SYNC_BIT, pick_delta(),
                                pick_delta(), $urandom_range(0, 99) < 15);
                end else if (roll < pkt_pct + pop_pct) begin
                    send_item(OP_POP, 8'($urandom_range(0, 255)));
                end else begin
                    send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d items: %0d packets queued, %0d dropped on a full queue, %0d resyncs",
                 items_sent, sb.completed - sb.dropped, sb.dropped, sb.resyncs);
        $display("pops: %0d returned an event, %0d found the queue empty; %0d results checked",
                 sb.pops_hit, sb.pops_empty, sb.checked);
        if (sb.errors == 0) begin
            $display("mouse_packet_assembler_queue_core test passed");
        end else begin
            $display("mouse_packet_assembler_queue_core test failed");
        end
        $finish;
    end

endmodule
